[rtl/core/lcs_pkg.sv]
// Package for the latency class statistics block: sizes, codes and shared types.
// Used by every module under rtl/core; depends on nothing else.
package lcs_pkg;

    localparam int NUM_CLASSES  = 9;
    localparam int BUCKET_SLOTS = 4;
    localparam int SAMPLE_BITS  = 32;
    localparam int MASK_BITS    = 9;
    localparam int RANGE_REGS   = 4;

    localparam logic [31:0] SAMPLE_MASK = 32'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [2:0]  BUCKETS_MAX = 3'(BUCKET_SLOTS);

    typedef enum logic [1:0] {
        REQ_RECORD = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req_type;

    typedef enum logic [2:0] {
        REG_IGNORE_MASK    = 3'd0,
        REG_BUCKETS_IN_USE = 3'd1,
        REG_BUCKET0_RANGE  = 3'd2,
        REG_BUCKET1_RANGE  = 3'd3,
        REG_BUCKET2_RANGE  = 3'd4,
        REG_BUCKET3_RANGE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [MASK_BITS-1:0]          ignore_mask;
        logic [2:0]                    buckets_in_use;
        logic [BUCKET_SLOTS-1:0][63:0] bucket_range;
    } t_cfg;

    typedef struct packed {
        logic [31:0] smallest;
        logic [31:0] largest;
        logic [31:0] count;
        logic [63:0] total;
    } t_class_stats;

    typedef logic [BUCKET_SLOTS-1:0][31:0] t_bucket_row;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  call_class;
        logic [31:0] sample_value;
        logic [1:0]  bucket_select;
    } t_item;

    localparam t_class_stats CLASS_RESET = '{
        smallest: SAMPLE_MASK,
        largest:  32'd0,
        count:    32'd0,
        total:    64'd0
    };

endpackage

[rtl/core/lcs_apb_regs.sv]
// Configuration register bank of the latency class statistics block, APB write and read.
// Depends on lcs_pkg.
module lcs_apb_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output lcs_pkg::t_cfg     o_cfg
);

    lcs_pkg::t_cfg r_cfg;
    lcs_pkg::t_cfg n_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            if (reg_idx == lcs_pkg::REG_IGNORE_MASK) begin
                n_cfg.ignore_mask = pwdata[lcs_pkg::MASK_BITS-1:0];
            end
            if (reg_idx == lcs_pkg::REG_BUCKETS_IN_USE) begin
                n_cfg.buckets_in_use = pwdata[2:0];
            end
            for (int b = 0; b < lcs_pkg::BUCKET_SLOTS; b++) begin
                if (b < lcs_pkg::RANGE_REGS &&
                    32'(reg_idx) == 32'(lcs_pkg::REG_BUCKET0_RANGE) + b) begin
                    n_cfg.bucket_range[b] = pwdata;
                end
            end
        end
    end

    always_comb begin
        prdata = 64'd0;
        if (reg_idx == lcs_pkg::REG_IGNORE_MASK) begin
            prdata = 64'(r_cfg.ignore_mask);
        end
        if (reg_idx == lcs_pkg::REG_BUCKETS_IN_USE) begin
            prdata = 64'(r_cfg.buckets_in_use);
        end
        for (int b = 0; b < lcs_pkg::BUCKET_SLOTS; b++) begin
            if (b < lcs_pkg::RANGE_REGS &&
                32'(reg_idx) == 32'(lcs_pkg::REG_BUCKET0_RANGE) + b) begin
                prdata = r_cfg.bucket_range[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/core/lcs_class_update.sv]
// Next-value logic for one class: min, max, saturating count and total, bucket hit.
// Depends on lcs_pkg.
module lcs_class_update (
    input  lcs_pkg::t_cfg         i_cfg,
    input  logic [3:0]            i_call_class,
    input  logic [31:0]           i_sample_value,
    input  lcs_pkg::t_class_stats i_stats,
    input  lcs_pkg::t_bucket_row  i_buckets,
    output logic                  o_write,
    output lcs_pkg::t_class_stats o_stats,
    output lcs_pkg::t_bucket_row  o_buckets
);

    logic                             masked;
    logic                             in_range;
    logic [2:0]                       used;
    logic [64:0]                      sum_ext;
    logic [lcs_pkg::BUCKET_SLOTS-1:0] hit;
    logic                             found;

    always_comb begin
        masked   = 1'b0;
        in_range = 1'b0;
        for (int m = 0; m < lcs_pkg::MASK_BITS; m++) begin
            if (32'(i_call_class) == m) begin
                masked = i_cfg.ignore_mask[m];
            end
        end
        for (int c = 0; c < lcs_pkg::NUM_CLASSES; c++) begin
            if (32'(i_call_class) == c) begin
                in_range = 1'b1;
            end
        end
        o_write = in_range && !masked;
    end

    assign used = (i_cfg.buckets_in_use > lcs_pkg::BUCKETS_MAX) ?
                  lcs_pkg::BUCKETS_MAX : i_cfg.buckets_in_use;
    assign sum_ext = {1'b0, i_stats.total} + 65'(i_sample_value);

    always_comb begin
        o_stats = i_stats;
        if (i_sample_value < i_stats.smallest) begin
            o_stats.smallest = i_sample_value;
        end
        if (i_sample_value > i_stats.largest) begin
            o_stats.largest = i_sample_value;
        end
        if (i_stats.count != '1) begin
            o_stats.count = i_stats.count + 32'd1;
        end
        o_stats.total = sum_ext[64] ? '1 : sum_ext[63:0];
    end

    always_comb begin
        for (int b = 0; b < lcs_pkg::BUCKET_SLOTS; b++) begin
            hit[b] = (32'(used) > b) &&
                     (i_sample_value >= i_cfg.bucket_range[b][31:0]) &&
                     (i_sample_value <= i_cfg.bucket_range[b][63:32]);
        end
    end

    always_comb begin
        o_buckets = i_buckets;
        found     = 1'b0;
        for (int b = 0; b < lcs_pkg::BUCKET_SLOTS; b++) begin
            if (hit[b] && !found) begin
                found = 1'b1;
                if (i_buckets[b] != '1) begin
                    o_buckets[b] = i_buckets[b] + 32'd1;
                end
            end
        end
    end

endmodule

[rtl/core/latency_class_statistics.sv]
// Top level of the latency class statistics block: input register, class store, result register.
// Depends on lcs_pkg, lcs_apb_regs and lcs_class_update.
//
// Request words enter on the s_axis channel; tuser carries the request type
// (record, query, clear), tdata the class, the sample and the bucket select.
// Only a query produces a word on the m_axis channel, carrying the class count,
// total, smallest and largest sample, and the selected bucket hit count.
// Each word is taken into an input register, processed by the combinational
// update logic, and a query result is held in an output register, from which
// it is driven onto m_axis. One request word is accepted in every cycle while
// no query is held back by a stalled receiver; the class store is read, updated
// and written back as the word leaves the input register.
// While the receiver stalls, a pending result is held and a following query
// waits in the input register; records and clears keep flowing until then.
// Reset, synchronous and active low, clears all statistics and the
// configuration registers; a clear word restores the statistics only.
// The user must write configuration through the APB port while the block is idle; it is not enforced.
module latency_class_statistics (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // call_class, sample_value, bucket_select, zero pad
    input  logic [1:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,  // sample_count, sample_total, smallest_sample,
                                        // largest_sample, bucket_hits
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    lcs_pkg::t_cfg         cfg;
    lcs_pkg::t_item        r_item;
    logic                  r_in_valid;
    logic                  r_out_valid;
    logic [191:0]          r_out_data;
    lcs_pkg::t_class_stats r_stats [lcs_pkg::NUM_CLASSES];
    lcs_pkg::t_bucket_row  r_buckets [lcs_pkg::NUM_CLASSES];

    lcs_pkg::t_class_stats cur_stats;
    lcs_pkg::t_bucket_row  cur_buckets;
    lcs_pkg::t_class_stats upd_stats;
    lcs_pkg::t_bucket_row  upd_buckets;
    logic                  upd_write;
    logic [31:0]           sel_hits;
    logic                  is_record;
    logic                  is_query;
    logic                  is_clear;
    logic                  advance;

    lcs_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign is_record = r_item.req_type == lcs_pkg::REQ_RECORD;
    assign is_query  = r_item.req_type == lcs_pkg::REQ_QUERY;
    assign is_clear  = r_item.req_type == lcs_pkg::REQ_CLEAR;

    assign advance       = r_in_valid && (!is_query || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        cur_stats   = lcs_pkg::CLASS_RESET;
        cur_buckets = '0;
        for (int c = 0; c < lcs_pkg::NUM_CLASSES; c++) begin
            if (32'(r_item.call_class) == c) begin
                cur_stats   = r_stats[c];
                cur_buckets = r_buckets[c];
            end
        end
        sel_hits = 32'd0;
        for (int b = 0; b < lcs_pkg::BUCKET_SLOTS; b++) begin
            if (32'(r_item.bucket_select) == b) begin
                sel_hits = cur_buckets[b];
            end
        end
    end

    lcs_class_update u_update (
        .i_cfg          (cfg),
        .i_call_class   (r_item.call_class),
        .i_sample_value (r_item.sample_value),
        .i_stats        (cur_stats),
        .i_buckets      (cur_buckets),
        .o_write        (upd_write),
        .o_stats        (upd_stats),
        .o_buckets      (upd_buckets)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.req_type      <= s_axis_tuser;
            r_item.call_class    <= s_axis_tdata[3:0];
            r_item.sample_value  <= s_axis_tdata[35:4] & lcs_pkg::SAMPLE_MASK;
            r_item.bucket_select <= s_axis_tdata[37:36];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && is_clear)) begin
            for (int c = 0; c < lcs_pkg::NUM_CLASSES; c++) begin
                r_stats[c]   <= lcs_pkg::CLASS_RESET;
                r_buckets[c] <= '0;
            end
        end else if (advance && is_record && upd_write) begin
            for (int c = 0; c < lcs_pkg::NUM_CLASSES; c++) begin
                if (32'(r_item.call_class) == c) begin
                    r_stats[c]   <= upd_stats;
                    r_buckets[c] <= upd_buckets;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_query) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_query) begin
            r_out_data <= {sel_hits, cur_stats.largest, cur_stats.smallest,
                           cur_stats.total, cur_stats.count};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[tb/latency_class_statistics_tb.sv]
// Testbench for latency_class_statistics: stream stimulus, APB setup and a scoreboard class.
// Depends on lcs_pkg and the latency_class_statistics RTL only.
// The scoreboard predicts each query result and checks the returned words field by field.
module latency_class_statistics_tb;

    localparam logic [1:0] REQ_UNKNOWN   = 2'd3;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [31:0] bucket_hits;
        logic [31:0] largest;
        logic [31:0] smallest;
        logic [63:0] total;
        logic [31:0] count;
    } t_query_report;

    class class_stats_mirror;
        logic [lcs_pkg::MASK_BITS-1:0] ignore_mask;
        logic [2:0]                    buckets_in_use;
        logic [63:0]                   ranges[lcs_pkg::BUCKET_SLOTS];
        logic [31:0]                   smallest[lcs_pkg::NUM_CLASSES];
        logic [31:0]                   largest[lcs_pkg::NUM_CLASSES];
        logic [31:0]                   count[lcs_pkg::NUM_CLASSES];
        logic [63:0]                   total[lcs_pkg::NUM_CLASSES];
        logic [31:0]                   hits[lcs_pkg::NUM_CLASSES][lcs_pkg::BUCKET_SLOTS];
        t_query_report                 pending_reports[$];
        int unsigned                   failures;
        int unsigned                   words_seen;
        int unsigned                   reports_checked;

        function new();
            ignore_mask    = '0;
            buckets_in_use = '0;
            foreach (ranges[b]) ranges[b] = '0;
            failures        = 0;
            words_seen      = 0;
            reports_checked = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            for (int c = 0; c < lcs_pkg::NUM_CLASSES; c++) begin
                smallest[c] = lcs_pkg::SAMPLE_MASK;
                largest[c]  = '0;
                count[c]    = '0;
                total[c]    = '0;
                for (int b = 0; b < lcs_pkg::BUCKET_SLOTS; b++) hits[c][b] = '0;
            end
        endfunction

        function void set_register(lcs_pkg::t_reg_idx idx, logic [63:0] val);
            case (idx)
                lcs_pkg::REG_IGNORE_MASK: begin
                    ignore_mask = val[lcs_pkg::MASK_BITS-1:0];
                end
                lcs_pkg::REG_BUCKETS_IN_USE: begin
                    buckets_in_use = val[2:0];
                end
                default: begin
                    ranges[int'(idx) - int'(lcs_pkg::REG_BUCKET0_RANGE)] = val;
                end
            endcase
        endfunction

        function void record_sample(int unsigned cls, logic [31:0] raw);
            logic [31:0] v;
            logic [31:0] lo;
            logic [31:0] hi;
            int unsigned used;
            bit          matched;
            v = raw & lcs_pkg::SAMPLE_MASK;
            if (cls >= lcs_pkg::NUM_CLASSES) return;
            if (cls < lcs_pkg::MASK_BITS && ignore_mask[cls]) return;
            if (v < smallest[cls]) smallest[cls] = v;
            if (v > largest[cls]) largest[cls] = v;
            if (count[cls] != '1) count[cls] = count[cls] + 32'd1;
            if (total[cls] > ~64'(v)) total[cls] = '1;
            else total[cls] = total[cls] + 64'(v);
            used    = (buckets_in_use > lcs_pkg::BUCKET_SLOTS) ?
                      lcs_pkg::BUCKET_SLOTS : buckets_in_use;
            matched = 0;
            for (int b = 0; b < used; b++) begin
                lo = ranges[b][31:0];
                hi = ranges[b][63:32];
                if (!matched && v >= lo && v <= hi) begin
                    matched = 1;
                    if (hits[cls][b] != '1) hits[cls][b] = hits[cls][b] + 32'd1;
                end
            end
        endfunction

        function void note_word(lcs_pkg::t_item it);
            t_query_report rep;
            int unsigned   cls;
            cls = it.call_class;
            words_seen++;
            case (it.req_type)
                lcs_pkg::REQ_RECORD: begin
                    record_sample(cls, it.sample_value);
                end
                lcs_pkg::REQ_CLEAR: begin
                    clear_stats();
                end
                lcs_pkg::REQ_QUERY: begin
                    if (cls < lcs_pkg::NUM_CLASSES) begin
                        rep.count       = count[cls];
                        rep.total       = total[cls];
                        rep.smallest    = smallest[cls];
                        rep.largest     = largest[cls];
                        rep.bucket_hits = (it.bucket_select < lcs_pkg::BUCKET_SLOTS) ?
                                          hits[cls][it.bucket_select] : 32'd0;
                    end else begin
                        rep.count       = '0;
                        rep.total       = '0;
                        rep.smallest    = lcs_pkg::SAMPLE_MASK;
                        rep.largest     = '0;
                        rep.bucket_hits = '0;
                    end
                    pending_reports.push_back(rep);
                end
                default: begin
                end
            endcase
        endfunction

        function void note_failure(string msg);
            if (failures < 10) $display("MISMATCH: %s", msg);
            failures++;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
                note_failure($sformatf("%s expected %h, got %h", name, want, got));
        endfunction

        function void check_report(logic [191:0] data);
            t_query_report got;
            t_query_report want;
            got = data;
            if (pending_reports.size() == 0) begin
                note_failure($sformatf("result word with nothing expected: %h", data));
                return;
            end
            want = pending_reports.pop_front();
            reports_checked++;
            compare_field("sample_count", 64'(want.count), 64'(got.count));
            compare_field("sample_total", want.total, got.total);
            compare_field("smallest_sample", 64'(want.smallest), 64'(got.smallest));
            compare_field("largest_sample", 64'(want.largest), 64'(got.largest));
            compare_field("bucket_hits", 64'(want.bucket_hits), 64'(got.bucket_hits));
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    class_stats_mirror mirror = new();

    int unsigned tx_idle_pct   = 0;
    int unsigned rx_stall_pct  = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned quiet_cycles  = 0;

    latency_class_statistics dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_served++;
            end
            m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) mirror.check_report(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(lcs_pkg::t_reg_idx idx, logic [63:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        mirror.set_register(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(logic [8:0] mask, logic [2:0] used, logic [63:0] r0,
                             logic [63:0] r1, logic [63:0] r2, logic [63:0] r3);
        write_reg(lcs_pkg::REG_IGNORE_MASK, 64'(mask));
        write_reg(lcs_pkg::REG_BUCKETS_IN_USE, 64'(used));
        write_reg(lcs_pkg::REG_BUCKET0_RANGE, r0);
        write_reg(lcs_pkg::REG_BUCKET1_RANGE, r1);
        write_reg(lcs_pkg::REG_BUCKET2_RANGE, r2);
        write_reg(lcs_pkg::REG_BUCKET3_RANGE, r3);
    endtask

    task automatic send_word(lcs_pkg::t_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, it.bucket_select, it.sample_value, it.call_class};
        s_axis_tuser  = it.req_type;
        do @(posedge i_clk); while (!s_axis_tready);
        mirror.note_word(it);
    endtask

    task automatic send_fields(logic [1:0] req, logic [3:0] cls, logic [31:0] v,
                               logic [1:0] sel);
        lcs_pkg::t_item it;
        it.req_type      = req;
        it.call_class    = cls;
        it.sample_value  = v;
        it.bucket_select = sel;
        send_word(it);
    endtask

    // Stops offering words, then lets every expected result and any trailing
    // record update finish before the configuration may change.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (mirror.pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_range();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(5000));
        case ($urandom_range(4))
            0: hi = lo - 32'($urandom_range(40) + 1);
            1: hi = 32'hFFFF_FFFF;
            default: hi = lo + 32'($urandom_range(3000));
        endcase
        return {hi, lo};
    endfunction

    function automatic lcs_pkg::t_item random_word();
        lcs_pkg::t_item it;
        int unsigned    pick;
        logic [63:0]    rng;
        pick = $urandom_range(99);
        if (pick < 62) it.req_type = lcs_pkg::REQ_RECORD;
        else if (pick < 97) it.req_type = lcs_pkg::REQ_QUERY;
        else if (pick < 98) it.req_type = lcs_pkg::REQ_CLEAR;
        else it.req_type = REQ_UNKNOWN;
        it.call_class = ($urandom_range(99) < 90) ?
                        4'($urandom_range(lcs_pkg::NUM_CLASSES - 1)) :
                        4'($urandom_range(15, lcs_pkg::NUM_CLASSES));
        rng = mirror.ranges[$urandom_range(lcs_pkg::BUCKET_SLOTS - 1)];
        case ($urandom_range(6))
            0: it.sample_value = $urandom();
            1: it.sample_value = rng[31:0];
            2: it.sample_value = rng[63:32];
            3: it.sample_value = rng[31:0] - 32'd1;
            4: it.sample_value = rng[63:32] + 32'd1;
            5: it.sample_value = 32'($urandom_range(255));
            default: it.sample_value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
        endcase
        it.bucket_select = 2'($urandom_range(3));
        return it;
    endfunction

    task automatic run_phase(int unsigned words, int unsigned tx_pct, int unsigned rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (words) send_word(random_word());
        drain();
    endtask

    initial begin
        lcs_pkg::t_item it;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        configure(9'h000, 3'd4, {32'd99, 32'd0}, {32'd999, 32'd100},
                  {32'hFFFF_FFFF, 32'd1000}, {32'd5, 32'd10});
        send_fields(lcs_pkg::REQ_QUERY, 4'd0, 32'd0, 2'd0);
        send_fields(lcs_pkg::REQ_RECORD, 4'd0, 32'd0, 2'd3);
        send_fields(lcs_pkg::REQ_RECORD, 4'd0, 32'hFFFF_FFFF, 2'd0);
        send_fields(lcs_pkg::REQ_RECORD, 4'd0, 32'd100, 2'd0);
        send_fields(lcs_pkg::REQ_RECORD, 4'd0, 32'd99, 2'd0);
        send_fields(lcs_pkg::REQ_RECORD, 4'd8, 32'd5000, 2'd0);
        send_fields(lcs_pkg::REQ_RECORD, 4'd15, 32'd7, 2'd0);
        send_fields(REQ_UNKNOWN, 4'd1, 32'd50, 2'd0);
        send_fields(lcs_pkg::REQ_QUERY, 4'd0, 32'd0, 2'd0);
        send_fields(lcs_pkg::REQ_QUERY, 4'd0, 32'd0, 2'd1);
        send_fields(lcs_pkg::REQ_QUERY, 4'd0, 32'd0, 2'd2);
        send_fields(lcs_pkg::REQ_QUERY, 4'd0, 32'd0, 2'd3);
        send_fields(lcs_pkg::REQ_QUERY, 4'd8, 32'd0, 2'd2);
        send_fields(lcs_pkg::REQ_QUERY, 4'd15, 32'hFFFF_FFFF, 2'd3);
        send_fields(lcs_pkg::REQ_QUERY, 4'd9, 32'd0, 2'd0);
        send_fields(lcs_pkg::REQ_QUERY, 4'd1, 32'd0, 2'd0);
        send_fields(lcs_pkg::REQ_CLEAR, 4'd0, 32'd0, 2'd0);
        send_fields(lcs_pkg::REQ_QUERY, 4'd0, 32'd0, 2'd1);
        send_fields(lcs_pkg::REQ_RECORD, 4'd3, 32'd12345, 2'd0);
        send_fields(lcs_pkg::REQ_QUERY, 4'd3, 32'd0, 2'd2);
        send_fields(REQ_UNKNOWN, 4'd15, 32'hFFFF_FFFF, 2'd3);
        drain();

        configure(9'h000, 3'd7, random_range(), random_range(), random_range(),
                  random_range());
        run_phase(165, 0, 0);
        configure(9'($urandom()), 3'd2, random_range(), random_range(), random_range(),
                  random_range());
        run_phase(165, 88, 0);
        configure(9'($urandom()), 3'd4, {32'd2000, 32'd0}, {32'd4000, 32'd1000},
                  random_range(), random_range());
        run_phase(165, 0, 88);
        configure(9'h000, 3'd5, 64'd0, {32'hFFFF_FFFF, 32'd0}, random_range(),
                  64'hFFFF_FFFF_FFFF_FFFF);
        run_phase(165, 17, 17);

        // Output held off for a long stretch while queries keep arriving, so
        // the result path fills and the input side has to stall.
        configure(9'h1FF, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_requests++;
        repeat (60) begin
            it = random_word();
            if ($urandom_range(9) != 0) it.req_type = lcs_pkg::REQ_QUERY;
            send_word(it);
        end
        drain();

        $display("Covered %0d request words and %0d checked query results across",
                 mirror.words_seen, mirror.reports_checked);
        $display("six register settings, four idle patterns and one long output hold-off.");
        if (mirror.failures == 0) begin
            $display("end of test: clean");
        end else begin
            $display("Failures: %0d", mirror.failures);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/lcs_pkg.sv
rtl/core/lcs_apb_regs.sv
rtl/core/lcs_class_update.sv
rtl/core/latency_class_statistics.sv
tb/latency_class_statistics_tb.sv
